FILE: rtl/core/animation_frame_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the animation frame sequencer
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define AFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Types, widths, mode codes and the remainder step for the frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int TW         = 48;                    // elapsed time width
	localparam int FPSW       = 16;                    // Q8.8 rate
	localparam int NW         = 11;                    // frame count width
	localparam int DW         = 12;                    // divisor / remainder width
	localparam int FW         = 10;                    // frame index width
	localparam int SW         = 39;                    // step width
	localparam int BPS        = 4;                     // quotient bits per stage
	localparam int NS         = (SW + BPS - 1) / BPS;  // remainder stages
	localparam int SPAD       = NS * BPS;
	localparam int OTW        = 16;                    // output tdata width
	localparam int CFG_AW     = 2;
	localparam int MAX_FRAMES = 1024;                  // frame count ceiling

	localparam logic [CFG_AW-1:0] CFG_FPS   = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_MODE  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_TOTAL = 2'd2;

	localparam logic [2:0] MODE_ONCE_FWD  = 3'd0;
	localparam logic [2:0] MODE_LOOP_FWD  = 3'd1;
	localparam logic [2:0] MODE_ONCE_BACK = 3'd2;
	localparam logic [2:0] MODE_LOOP_BACK = 3'd3;
	localparam logic [2:0] MODE_ONCE_PP   = 3'd4;
	localparam logic [2:0] MODE_LOOP_PP   = 3'd5;
	localparam logic [2:0] MODE_NONE      = 3'd6;

	typedef struct packed {
		logic [FW-1:0] frame;
		logic          done;
	} afs_side_t;

	// BPS steps of restoring remainder
	function automatic logic [DW-1:0] mod_bits(input logic [DW-1:0] rem,
			input logic [BPS-1:0] bits, input logic [DW-1:0] d);
		logic [DW:0] r;
		r = {1'b0, rem};
		for (int i = BPS - 1; i >= 0; i--) begin
			r = {r[DW-1:0], bits[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
			end
		end
		return r[DW-1:0];
	endfunction

endpackage

FILE: rtl/core/afs_mod_pipe.sv
// ----------------------------------------------------------------------------
// afs_mod_pipe
// Pipelined step remainder, BPS quotient bits per stage, elastic valid chain.
// ----------------------------------------------------------------------------
module afs_mod_pipe import afs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [DW-1:0] divisor,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [SW-1:0] in_step,
	input  afs_side_t     in_side,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_rem,
	output afs_side_t     out_side
);

	logic            v_s    [NS];
	logic [DW-1:0]   rem_s  [NS];
	logic [SPAD-1:0] bits_s [NS];
	afs_side_t       side_s [NS];
	logic [NS:0]     rdy;
	logic [SPAD-1:0] step_pad;

	assign step_pad = {{(SPAD-SW){1'b0}}, in_step};

	always_comb begin
		rdy[NS] = out_ready;
		for (int i = NS - 1; i >= 0; i--) begin
			rdy[i] = !v_s[i] || rdy[i+1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[NS-1];
	assign out_rem   = rem_s[NS-1];
	assign out_side  = side_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem_s[0]  <= mod_bits('0, step_pad[SPAD-1 -: BPS], divisor);
			bits_s[0] <= step_pad << BPS;
			side_s[0] <= in_side;
		end
	end

	for (genvar g = 1; g < NS; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				v_s[g] <= v_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && v_s[g-1]) begin
				rem_s[g]  <= mod_bits(rem_s[g-1], bits_s[g-1][SPAD-1 -: BPS], divisor);
				bits_s[g] <= bits_s[g-1] << BPS;
				side_s[g] <= side_s[g-1];
			end
		end
	end

endmodule

FILE: rtl/core/animation_frame_sequencer.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// Elapsed time to sprite frame index under forward, backward and ping-pong play.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   tdata: elapsed_time[47:0]
// m_axis    out  tdata: frame_index[9:0], done_flag[10], zero pad
// cfg       in   cfg_addr 0 rate, 1 mode, 2 frame total
//
// One item per cycle while the output is not stalled; the stages are a split 47x16 multiply,
// a step add, a remainder pipeline taking 4 step bits per stage, then the output register.
// Ready is combinational through all stages; a stall holds only the full
// stages ahead of the first bubble, bubbles are squeezed out.
// Reset clears valids and loads the config reset values (rate 0, loop fwd, 0).
// ----------------------------------------------------------------------------
module animation_frame_sequencer import afs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [TW-1:0]     s_axis_tdata,   // elapsed_time
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OTW-1:0]    m_axis_tdata,   // frame_index, done_flag, pad
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [FPSW-1:0]   cfg_wdata
);

	logic [FPSW-1:0] fps_q;
	logic [2:0]      mode_q;
	logic [NW-1:0]   total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q   <= '0;
			mode_q  <= MODE_LOOP_FWD;
			total_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FPS:   fps_q   <= cfg_wdata;
				CFG_MODE:  mode_q  <= cfg_wdata[2:0];
				CFG_TOTAL: total_q <= cfg_wdata[NW-1:0];
				default: ;
			endcase
		end
	end

	// derived config
	logic [NW-1:0] n;
	logic [NW-1:0] nm1;
	logic [DW-1:0] period;
	logic [DW-1:0] divisor;
	logic          trivial;

	always_comb begin
		if (32'(total_q) > 32'(MAX_FRAMES)) begin
			n = NW'(MAX_FRAMES);
		end else begin
			n = total_q;
		end
		nm1     = n - NW'(1);
		period  = {n, 1'b0} - DW'(2);
		divisor = (mode_q == MODE_LOOP_PP) ? period : {1'b0, n};
		trivial = (n <= NW'(1)) || (mode_q == MODE_NONE);
	end

	// handshake chain
	logic rdy1, rdy2, rdy_out;
	logic mod_in_ready, mod_out_valid;
	logic v_s1, v_s2, vout_q;

	assign rdy_out       = !vout_q || m_axis_tready;
	assign rdy2          = !v_s2 || mod_in_ready;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vout_q;

	// stage 1: split multiply
	logic [TW-2:0] t_pos;
	logic [47:0]   plo_s1;
	logic [30:0]   phi_s1;

	assign t_pos = s_axis_tdata[TW-1] ? '0 : s_axis_tdata[TW-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			plo_s1 <= t_pos[31:0] * fps_q;
			phi_s1 <= t_pos[TW-2:32] * fps_q;
		end
	end

	// stage 2: step = product >> 24
	logic [SW-1:0] step_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			step_s2 <= {phi_s1, 8'b0} + SW'(plo_s1[47:24]);
		end
	end

	// once-mode results ride alongside the remainder
	afs_side_t side_c;
	logic      ge_nm1, ge_per, lt_n;
	logic [DW-1:0] pp_f;

	always_comb begin
		ge_nm1 = step_s2 >= SW'(nm1);
		ge_per = step_s2 >= SW'(period);
		lt_n   = step_s2 < SW'(n);
		pp_f   = lt_n ? step_s2[DW-1:0] : (period - step_s2[DW-1:0]);
		side_c = '0;
		unique case (mode_q)
			MODE_ONCE_FWD: begin
				side_c.done  = ge_nm1;
				side_c.frame = ge_nm1 ? nm1[FW-1:0] : step_s2[FW-1:0];
			end
			MODE_ONCE_BACK: begin
				side_c.done  = ge_nm1;
				side_c.frame = ge_nm1 ? '0 : FW'(nm1 - step_s2[NW-1:0]);
			end
			MODE_ONCE_PP: begin
				side_c.done  = ge_per;
				side_c.frame = ge_per ? '0 : pp_f[FW-1:0];
			end
			default: ;
		endcase
	end

	logic [DW-1:0] mod_rem;
	afs_side_t     mod_side;

	afs_mod_pipe u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.divisor   (divisor),
		.in_valid  (v_s2),
		.in_ready  (mod_in_ready),
		.in_step   (step_s2),
		.in_side   (side_c),
		.out_valid (mod_out_valid),
		.out_ready (rdy_out),
		.out_rem   (mod_rem),
		.out_side  (mod_side)
	);

	// final mapping
	logic [DW-1:0] frame_c;
	logic          done_c;

	always_comb begin
		frame_c = mod_rem;
		done_c  = 1'b0;
		unique case (mode_q)
			MODE_ONCE_FWD, MODE_ONCE_BACK, MODE_ONCE_PP: begin
				frame_c = DW'(mod_side.frame);
				done_c  = mod_side.done;
			end
			MODE_LOOP_BACK: frame_c = {1'b0, nm1} - mod_rem;
			MODE_LOOP_PP:   frame_c = (mod_rem < {1'b0, n}) ? mod_rem : (period - mod_rem);
			default:        frame_c = mod_rem;
		endcase
		if (trivial) begin
			frame_c = '0;
			done_c  = 1'b1;
		end else if (fps_q == '0) begin
			frame_c = '0;
			done_c  = 1'b0;
		end
	end

	logic [FW-1:0] frame_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q <= 1'b0;
		end else if (rdy_out) begin
			vout_q <= mod_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && mod_out_valid) begin
			frame_q <= frame_c[FW-1:0];
			done_q  <= done_c;
		end
	end

	assign m_axis_tdata = {(OTW-FW-1)'(0), done_q, frame_q};

endmodule

FILE: rtl/core/afs_checker.sv
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks on the frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "animation_frame_sequencer_defines.svh"

module afs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// an empty output stage frees the whole pipe
	`AFS_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with output empty")

	// a draining output frees the whole pipe
	`AFS_ASSERT_IMP(a_drain_ready, m_axis_tready, s_axis_tready, "input stalled while output drains")

	`AFS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0, "tdata pad bits set")

	`AFS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (.*);
